>>> src/awd_pkg.sv
// Shared types, constants and the exponential node tables for the waveshaper.
// Used by awd_shaper and audio_waveshaper_distortion_top; depends on nothing.
package awd_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int FRAC_W    = 20;
	localparam int MODE_W    = 3;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [MODE_W-1:0] MODE_HARD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SOFT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_EXP    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FULL   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HALF   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BYPASS = 3'd5;

	localparam logic [0:0] REG_MODE = 1'b0;

	localparam int UNIT      = 1 << FRAC_W;
	localparam int EXP_LOG2  = 8;
	localparam int EXP_DEPTH = 1 << EXP_LOG2;
	localparam int SPAN_LOG2 = 3;
	localparam int POS_SHIFT = FRAC_W + SPAN_LOG2 - EXP_LOG2;
	localparam int IDX_W     = SAMPLE_W - POS_SHIFT;
	localparam int NODE_W    = FRAC_W + 1;
	localparam int STEP_W    = FRAC_W;
	localparam int PROD_W    = STEP_W + POS_SHIFT;
	localparam int POW_CNT   = 13;

	localparam int M3_W      = SAMPLE_W + 2;
	localparam int USQ_W     = 2 * FRAC_W;
	localparam int KNEE_W    = 2 * FRAC_W + 3;
	localparam int KQ_W      = FRAC_W + 2;
	localparam int DIV3_SHIFT = KQ_W + 3;
	localparam int RECIP_W   = DIV3_SHIFT - 1;
	localparam int KPROD_W   = KQ_W + RECIP_W;

	localparam longint unsigned UNIT_L = 64'd1 << FRAC_W;
	localparam logic [KNEE_W-1:0] KNEE_NUM = KNEE_W'(3 * UNIT_L * UNIT_L + 3 * UNIT_L);
	localparam logic [RECIP_W-1:0] DIV3_RECIP = RECIP_W'(((64'd1 << DIV3_SHIFT) / 3) + 1);

	typedef logic [NODE_W-1:0] node_tab_t [EXP_DEPTH+1];
	typedef logic [NODE_W-1:0] base_tab_t [EXP_DEPTH];
	typedef logic [STEP_W-1:0] step_tab_t [EXP_DEPTH];

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic                       neg;
		logic [SAMPLE_W-1:0]        mag;
		logic [MODE_W-1:0]          mode;
	} smp_t;

	typedef struct packed {
		logic lo;
		logic hi;
		logic far;
	} knee_flags_t;

	function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 30)) >> 31;
	endfunction

	// nodes 1-exp(-8k/depth), exp built from squared powers of a Taylor exp(-d)
	function automatic node_tab_t build_nodes();
		longint unsigned pw [POW_CNT];
		longint unsigned one;
		longint unsigned d;
		longint unsigned term;
		longint unsigned tp;
		longint unsigned e;
		longint unsigned g;
		longint signed   sum;
		node_tab_t       t;
		one  = 64'd1 << 31;
		d    = ((64'd1 << (31 + SPAN_LOG2)) + EXP_DEPTH / 2) / EXP_DEPTH;
		term = one;
		sum  = longint'(one);
		for (int n = 1; n <= 13; n++) begin
			tp = (term * d) >> 31;
			case (n)
				1: term = tp;
				2: term = tp / 2;
				3: term = tp / 3;
				4: term = tp / 4;
				5: term = tp / 5;
				6: term = tp / 6;
				7: term = tp / 7;
				8: term = tp / 8;
				9: term = tp / 9;
				10: term = tp / 10;
				11: term = tp / 11;
				12: term = tp / 12;
				13: term = tp / 13;
				default: term = tp;
			endcase
			if ((n & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		pw[0] = longint'(sum);
		for (int j = 1; j < POW_CNT; j++)
			pw[j] = q31_mul(pw[j-1], pw[j-1]);
		for (int k = 0; k <= EXP_DEPTH; k++) begin
			e = one;
			for (int j = 0; j < POW_CNT; j++)
				if (((k >> j) & 1) == 1)
					e = q31_mul(e, pw[j]);
			g = one - e;
			t[k] = NODE_W'((g + (64'd1 << (30 - FRAC_W))) >> (31 - FRAC_W));
		end
		return t;
	endfunction

	localparam node_tab_t EXP_NODES = build_nodes();

	function automatic base_tab_t build_base();
		base_tab_t b;
		for (int k = 0; k < EXP_DEPTH; k++)
			b[k] = EXP_NODES[k];
		return b;
	endfunction

	function automatic step_tab_t build_step();
		step_tab_t s;
		for (int k = 0; k < EXP_DEPTH; k++)
			s[k] = STEP_W'(EXP_NODES[k+1] - EXP_NODES[k]);
		return s;
	endfunction

	localparam base_tab_t EXP_BASE = build_base();
	localparam step_tab_t EXP_STEP = build_step();
	localparam logic [NODE_W-1:0] EXP_LAST = EXP_NODES[EXP_DEPTH];

endpackage

>>> src/awd_shaper.sv
// Six-stage shaping pipeline with valid/stall flow control.
// Depends on awd_pkg for widths, mode codes and the exponential tables.
module awd_shaper (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [awd_pkg::MODE_W-1:0]           mode,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [awd_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [awd_pkg::SAMPLE_W-1:0]  sample_out
);
	import awd_pkg::*;

	localparam logic signed [SAMPLE_W:0] HALF_P  = (SAMPLE_W+1)'(UNIT / 2);
	localparam logic signed [SAMPLE_W:0] HALF_N  = -HALF_P;
	localparam logic signed [SAMPLE_W:0] SAT_MAX = (SAMPLE_W+1)'((64'd1 << (SAMPLE_W-1)) - 1);
	localparam logic signed [SAMPLE_W:0] SAT_MIN = -SAT_MAX - HALF_P / HALF_P;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en1, en2, en3, en4, en5, en6;

	smp_t smp_a;
	smp_t smp_s1, smp_s2, smp_s3, smp_s4, smp_s5;
	knee_flags_t fl_b;
	knee_flags_t fl_s2, fl_s3, fl_s4, fl_s5;

	logic [M3_W-1:0]   m3_b;
	logic [M3_W-1:0]   u_full_b;
	logic [IDX_W-1:0]  idx_b;
	logic [NODE_W-1:0] base_b;
	logic [STEP_W-1:0] step_b;

	logic [FRAC_W-1:0]    u_s2;
	logic [NODE_W-1:0]    base_s2, base_s3;
	logic [STEP_W-1:0]    step_s2;
	logic [POS_SHIFT-1:0] frac_s2;
	logic [USQ_W-1:0]     usq_s3;
	logic [PROD_W-1:0]    prod_s3;
	logic [NODE_W-1:0]    interp_s4, interp_s5;
	logic [KQ_W-1:0]      kq_s4;
	logic [KPROD_W-1:0]   kprod_s5;

	logic [KNEE_W-1:0]      knum_d;
	logic [SAMPLE_W-1:0]    soft_mag;
	logic signed [SAMPLE_W:0] x_e, soft_v, exp_v, y, y_sat;
	logic signed [SAMPLE_W-1:0] sample_s6;

	// flow control: a stage loads when empty or when the next one loads
	assign en6 = !vld_s6 || !out_stall;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_stall   = !en1;
	assign out_valid  = vld_s6;
	assign sample_out = sample_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: sign and magnitude
	always_comb begin
		smp_a.x    = sample_in;
		smp_a.neg  = sample_in[SAMPLE_W-1];
		smp_a.mag  = smp_a.neg ? SAMPLE_W'(-sample_in) : SAMPLE_W'(sample_in);
		smp_a.mode = mode;
	end

	// stage 2: knee thresholds, table lookup
	always_comb begin
		m3_b     = {2'b00, smp_s1.mag} + {1'b0, smp_s1.mag, 1'b0};
		u_full_b = M3_W'(2 * UNIT) - m3_b;
		fl_b.lo  = m3_b <= M3_W'(UNIT);
		fl_b.hi  = m3_b > M3_W'(2 * UNIT);
		idx_b    = smp_s1.mag[SAMPLE_W-1:POS_SHIFT];
		fl_b.far = idx_b >= IDX_W'(EXP_DEPTH);
		base_b   = fl_b.far ? EXP_LAST : EXP_BASE[idx_b[EXP_LOG2-1:0]];
		step_b   = fl_b.far ? '0 : EXP_STEP[idx_b[EXP_LOG2-1:0]];
	end

	// stage 4: knee numerator
	assign knum_d = KNEE_NUM - KNEE_W'(usq_s3);

	// stage 6: select and saturate
	always_comb begin
		x_e      = (SAMPLE_W+1)'(smp_s5.x);
		soft_mag = fl_s5.lo ? smp_s5.mag :
		           fl_s5.hi ? SAMPLE_W'(UNIT / 2) :
		           SAMPLE_W'(kprod_s5 >> DIV3_SHIFT);
		soft_v   = signed'({1'b0, soft_mag});
		exp_v    = signed'((SAMPLE_W+1)'(interp_s5));
		case (smp_s5.mode)
			MODE_HARD: begin
				if (x_e > HALF_P)
					y = HALF_P;
				else if (x_e < HALF_N)
					y = HALF_N;
				else
					y = x_e;
			end
			MODE_SOFT: y = smp_s5.neg ? -soft_v : soft_v;
			MODE_EXP:  y = smp_s5.neg ? -exp_v : exp_v;
			MODE_FULL: y = signed'({1'b0, smp_s5.mag});
			MODE_HALF: y = smp_s5.neg ? '0 : x_e;
			default:   y = x_e;
		endcase
		if (y > SAT_MAX)
			y_sat = SAT_MAX;
		else if (y < SAT_MIN)
			y_sat = SAT_MIN;
		else
			y_sat = y;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			smp_s1 <= smp_a;
		end
		if (en2) begin
			smp_s2  <= smp_s1;
			fl_s2   <= fl_b;
			u_s2    <= u_full_b[FRAC_W-1:0];
			base_s2 <= base_b;
			step_s2 <= step_b;
			frac_s2 <= smp_s1.mag[POS_SHIFT-1:0];
		end
		if (en3) begin
			smp_s3  <= smp_s2;
			fl_s3   <= fl_s2;
			base_s3 <= base_s2;
			usq_s3  <= USQ_W'(u_s2) * USQ_W'(u_s2);
			prod_s3 <= PROD_W'(step_s2) * PROD_W'(frac_s2);
		end
		if (en4) begin
			smp_s4    <= smp_s3;
			fl_s4     <= fl_s3;
			interp_s4 <= base_s3 +
			             NODE_W'((prod_s3 + PROD_W'(1 << (POS_SHIFT - 1))) >> POS_SHIFT);
			kq_s4     <= KQ_W'(knum_d >> (FRAC_W + 1));
		end
		if (en5) begin
			smp_s5    <= smp_s4;
			fl_s5     <= fl_s4;
			interp_s5 <= interp_s4;
			kprod_s5  <= KPROD_W'(kq_s4) * KPROD_W'(DIV3_RECIP);
		end
		if (en6) begin
			sample_s6 <= y_sat[SAMPLE_W-1:0];
		end
	end

endmodule

>>> src/audio_waveshaper_distortion_top.sv
// Audio waveshaper top level: APB mode register and the shaping pipeline.
// Depends on awd_pkg and awd_shaper.
//
// Usage: one signed sample word enters on in_valid/in_stall/sample_in and one
// shaped word leaves on out_valid/out_stall/sample_out. A word is taken at a
// rising edge with valid high and stall low. The curve is picked by the
// distortion_mode register at APB byte address 0 (hard clip, soft clip,
// exponential soft clip, full-wave, half-wave, bypass; codes 6 and 7 bypass).
// Throughput is one word per cycle while out_stall stays low; the result
// passes through the six register stages of awd_shaper (table read, two
// multiplier stages for the knee and interpolation, select/saturate).
// When out_stall holds a result, the stages behind it keep filling their
// empty slots; in_stall rises only when every stage holds a word. Reset
// empties the pipeline and sets the mode to hard clip. The mode should be
// written only while no word is in flight.
module audio_waveshaper_distortion_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [awd_pkg::ADDR_W-1:0]           paddr,
	input  logic [awd_pkg::DATA_W-1:0]           pwdata,
	output logic [awd_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [awd_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [awd_pkg::SAMPLE_W-1:0]  sample_out
);
	import awd_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              wr_mode;

	assign pready  = 1'b1;
	assign wr_mode = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MODE);
	assign prdata  = (paddr[ADDR_W-1] == REG_MODE) ? DATA_W'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HARD;
		end else if (wr_mode) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	awd_shaper u_shaper (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	// input is held off only when the pipeline is full behind a stalled result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	// an unstalled output always frees the input
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// a mode write lands and reads back on the next cycle
	a_mode_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_mode |=> (mode_q == $past(pwdata[MODE_W-1:0])) &&
		            (paddr[ADDR_W-1] != REG_MODE || prdata == DATA_W'(mode_q)))
		else $error("mode register write lost");

endmodule
